/* design/lpr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package lpr_pkg;

    // Configuration register width and reset value (frame limit)
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 5'd16;

    // Fixed output field widths
    localparam int FRAME_INDEX_W = 4;
    localparam int COUNT_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_COMMIT
    } lpr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_page;
        logic lookup;
        logic scan_step;
        logic commit;
    } lpr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic full;
        logic limit_one;
        logic scan_last;
        logic out_busy;
    } lpr_status_t;

endpackage

`default_nettype wire

/* design/lpr_ctrl.sv */
// Sequencer for the LRU page replacement block: accept, lookup, victim scan, commit.
// Depends on lpr_pkg for the state, command and status types.
`default_nettype none

module lpr_ctrl
    import lpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire lpr_status_t status,
    output lpr_cmd_t         cmd
);

    lpr_state_t state_reg;
    lpr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_page = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                // walk the ranks only when a victim must be chosen among several frames
                if (!status.hit && status.full && !status.limit_one)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/lpr_datapath.sv */
// Frame store, recency ranks, lookup, victim scan, counters and output register.
// Depends on lpr_pkg for the command and status types and field widths.
`default_nettype none

module lpr_datapath
    import lpr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [PAGE_BITS-1:0]     page,
    input  wire logic [CFG_W-1:0]         limit_cfg,
    input  wire lpr_cmd_t                 cmd,
    output lpr_status_t                   status,
    input  wire logic                     out_stall,
    output logic                          out_valid,
    output logic                          hit,
    output logic [FRAME_INDEX_W-1:0]      frame_index,
    output logic                          evicted,
    output logic [PAGE_BITS-1:0]          evicted_page,
    output logic [COUNT_W-1:0]            hit_total,
    output logic [COUNT_W-1:0]            fault_total
);

    localparam int IW = $clog2(FRAMES);
    localparam int LW = $clog2(FRAMES + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;

    // Frame state
    logic [PAGE_BITS-1:0] page_store [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [IW-1:0]        rank_reg [FRAMES];
    logic [LW-1:0]        fill_count_reg;
    logic [COUNT_W-1:0]   hit_count_reg;
    logic [COUNT_W-1:0]   fault_count_reg;

    // Per-item working registers
    logic [PAGE_BITS-1:0] page_q_reg;
    logic                 hit_reg;
    logic                 evict_reg;
    logic [IW-1:0]        target_reg;
    logic [IW-1:0]        best_rank_reg;
    logic [IW-1:0]        scan_idx_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [IW-1:0]        out_frame_reg;
    logic                 out_evicted_reg;
    logic [PAGE_BITS-1:0] out_evicted_page_reg;

    logic [CW-1:0]        cfg_ext;
    logic [LW-1:0]        limit;
    logic                 found;
    logic [IW-1:0]        match_idx;
    logic                 full;
    logic [IW-1:0]        sel_rank;
    logic [PAGE_BITS-1:0] sel_page;
    logic                 touch_mode;
    logic [IW+FRAME_INDEX_W-1:0] frame_ext;

    // Clamp the configured limit to 1..FRAMES
    always_comb
    begin
        cfg_ext = CW'(limit_cfg);
        if (cfg_ext == '0)
        begin
            limit = LW'(1);
        end
        else if (cfg_ext > CW'(FRAMES))
        begin
            limit = LW'(FRAMES);
        end
        else
        begin
            limit = cfg_ext[LW-1:0];
        end
    end

    // Parallel compare; lowest matching frame wins
    always_comb
    begin
        found     = 1'b0;
        match_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (page_store[i] == page_q_reg) && (LW'(i) < limit))
            begin
                found     = 1'b1;
                match_idx = IW'(i);
            end
        end
    end

    assign full = (fill_count_reg >= limit);

    // One-hot pick of the target frame's rank and page
    always_comb
    begin
        sel_rank = '0;
        sel_page = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (target_reg == IW'(i))
            begin
                sel_rank = sel_rank | rank_reg[i];
                sel_page = sel_page | page_store[i];
            end
        end
    end

    assign touch_mode = hit_reg || evict_reg;

    always_comb
    begin
        status.hit       = found;
        status.full      = full;
        status.limit_one = (limit == LW'(1));
        status.scan_last = (LW'(scan_idx_reg) == (limit - LW'(1)));
        status.out_busy  = out_valid_reg && out_stall;
    end

    // Working registers: capture, lookup, victim scan
    always_ff @(posedge clk)
    begin
        if (cmd.load_page)
        begin
            page_q_reg <= page;
        end
        if (cmd.lookup)
        begin
            hit_reg       <= found;
            evict_reg     <= !found && full;
            best_rank_reg <= rank_reg[0];
            scan_idx_reg  <= IW'(1);
            if (found)
            begin
                target_reg <= match_idx;
            end
            else if (full)
            begin
                target_reg <= '0;
            end
            else
            begin
                target_reg <= fill_count_reg[IW-1:0];
            end
        end
        if (cmd.scan_step)
        begin
            if (rank_reg[scan_idx_reg] > best_rank_reg)
            begin
                best_rank_reg <= rank_reg[scan_idx_reg];
                target_reg    <= scan_idx_reg;
            end
            scan_idx_reg <= scan_idx_reg + IW'(1);
        end
    end

    // Page store has no reset; entries are read only once valid
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            page_store[target_reg] <= page_q_reg;
        end
    end

    // Ranks, valid bits, fill count and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            fill_count_reg  <= '0;
            hit_count_reg   <= '0;
            fault_count_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                if (target_reg == IW'(i))
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && (!touch_mode || (rank_reg[i] < sel_rank)))
                begin
                    rank_reg[i] <= rank_reg[i] + IW'(1);
                end
            end
            if (!touch_mode)
            begin
                valid_reg[target_reg] <= 1'b1;
                fill_count_reg        <= fill_count_reg + LW'(1);
            end
            if (hit_reg)
            begin
                if (!(&hit_count_reg))
                begin
                    hit_count_reg <= hit_count_reg + COUNT_W'(1);
                end
            end
            else if (!(&fault_count_reg))
            begin
                fault_count_reg <= fault_count_reg + COUNT_W'(1);
            end
        end
    end

    // Output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg          <= hit_reg;
            out_frame_reg        <= target_reg;
            out_evicted_reg      <= evict_reg;
            out_evicted_page_reg <= evict_reg ? sel_page : '0;
        end
    end

    assign frame_ext    = {{FRAME_INDEX_W{1'b0}}, out_frame_reg};
    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign frame_index  = frame_ext[FRAME_INDEX_W-1:0];
    assign evicted      = out_evicted_reg;
    assign evicted_page = out_evicted_page_reg;
    // totals change only at commit, which waits for a free output register
    assign hit_total    = hit_count_reg;
    assign fault_total  = fault_count_reg;

endmodule

`default_nettype wire

/* design/lru_page_replacement.sv */
// LRU page replacement monitor: each accepted page is looked up, then on an eviction among
// several frames (limit = frames in use, 1..FRAMES) a victim is searched, then it is committed.
// One page is in flight at a time: the next page is accepted only after the last one commits;
// the victim search reads one frame's rank per cycle.
// Reset (async, active low) clears valid bits, ranks, fill count and totals and sets the
// frame limit to 16; the page store is not cleared and needs no clearing pass.
`default_nettype none

module lru_page_replacement
    import lpr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration: frame limit register
    input  wire logic                 cfg_write,
    input  wire logic [CFG_W-1:0]     frame_limit,
    // page reference channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [PAGE_BITS-1:0] page,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      hit,
    output logic [FRAME_INDEX_W-1:0]  frame_index,
    output logic                      evicted,
    output logic [PAGE_BITS-1:0]      evicted_page,
    output logic [COUNT_W-1:0]        hit_total,
    output logic [COUNT_W-1:0]        fault_total
);

    logic [CFG_W-1:0] limit_cfg_reg;
    lpr_cmd_t         cmd;
    lpr_status_t      status;

    // Frame limit register; the user must write it only while the block is idle (not enforced here).
    // Clamping to 1..FRAMES happens in the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg <= CFG_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_cfg_reg <= frame_limit;
        end
    end

    // Sequencer: accept one word, look it up, scan for a victim if needed, commit.
    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: parallel tag compare over all frames, rank aging in one step at commit,
    // saturating totals, and the output register that lets the next word in while a
    // result waits to be taken.
    lpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .page         (page),
        .limit_cfg    (limit_cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .hit          (hit),
        .frame_index  (frame_index),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .fault_total  (fault_total)
    );

`ifndef SYNTHESIS
    // Commit never overwrites a result word that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("commit while result word is stalled");

    // One page in flight: an accepted word blocks the input next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while one is in flight");

    // Totals never go down
    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hit_total >= $past(hit_total)))
        else $error("hit total decreased");

    a_faults_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fault_total >= $past(fault_total)))
        else $error("fault total decreased");
`endif

endmodule

`default_nettype wire

/* sim/lru_page_replacement_test.sv */
// Self-checking testbench for lru_page_replacement: streams page references,
// predicts hit/fault, frame, victim and totals, and checks every result word.
// Depends on lpr_pkg and the lru_page_replacement RTL only.
`timescale 1ns / 1ps

module lru_page_replacement_test
    import lpr_pkg::*;
();

    localparam int FRAMES        = 16;
    localparam int PAGE_BITS     = 16;
    localparam int ITEMS_TOTAL   = 1850;
    localparam int SETTLE_CYCLES = 24;        // longest eviction latency plus margin
    localparam longint TIMEOUT_NS = 5_000_000; // watchdog limit for the whole run

    // Receiver back-pressure styles
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // One expected result word
    typedef struct {
        logic                     hit;
        logic [FRAME_INDEX_W-1:0] frame;
        logic                     evicted;
        logic [PAGE_BITS-1:0]     evicted_page;
        logic [COUNT_W-1:0]       hit_total;
        logic [COUNT_W-1:0]       fault_total;
    } page_outcome_t;

    // Clock, reset and DUT ports; every input starts at a known value
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_W-1:0]         frame_limit = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [PAGE_BITS-1:0]     page = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     hit;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     evicted;
    logic [PAGE_BITS-1:0]     evicted_page;
    logic [COUNT_W-1:0]       hit_total;
    logic [COUNT_W-1:0]       fault_total;

    // Pages waiting to be sent, and result words waiting to arrive
    logic [PAGE_BITS-1:0] page_queue[$];
    page_outcome_t        pending_results[$];

    // Shadow of the frame table, kept in step with every accepted page
    logic [PAGE_BITS-1:0] held_page[FRAMES];
    bit                   held_valid[FRAMES];
    int                   age_rank[FRAMES];
    int                   filled = 0;
    logic [COUNT_W-1:0]   hit_tally = '0;
    logic [COUNT_W-1:0]   fault_tally = '0;
    logic [CFG_W-1:0]     limit_reg = CFG_LIMIT_RESET;

    // Run statistics
    int mismatches = 0;
    int words_checked = 0;
    int seen_hits = 0;
    int seen_faults = 0;
    int seen_evictions = 0;
    int limit_writes = 0;

    // Driver and receiver pacing
    int          burst_left = 0;
    int          gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          stall_period = 2;
    int          stall_tick = 0;

    lru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .frame_limit  (frame_limit),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .page         (page),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .frame_index  (frame_index),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .fault_total  (fault_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Make frame f most recent: only valid frames younger than it age by one.
    function automatic void promote_frame(input int f);
        int i;
        for (i = 0; i < FRAMES; i++)
        begin
            if (held_valid[i] && i != f && age_rank[i] < age_rank[f])
                age_rank[i]++;
        end
        age_rank[f] = 0;
    endfunction

    // Apply one page reference to the shadow table and return the word it must produce.
    function automatic page_outcome_t predict_reference(input logic [PAGE_BITS-1:0] pg);
        page_outcome_t res;
        int lim;
        int i;
        int f;
        bit found;
        // A limit of zero behaves as one; anything past the built size is clamped.
        if (limit_reg == 0)
            lim = 1;
        else if (limit_reg > FRAMES)
            lim = FRAMES;
        else
            lim = int'(limit_reg);
        found = 1'b0;
        f = 0;
        // Lowest matching frame inside the limit wins; frames above it are invisible.
        for (i = 0; i < lim && !found; i++)
        begin
            if (held_valid[i] && held_page[i] == pg)
            begin
                f = i;
                found = 1'b1;
            end
        end
        res.evicted = 1'b0;
        res.evicted_page = '0;
        if (found)
        begin
            promote_frame(f);
            if (hit_tally != '1)
                hit_tally++;
        end
        else
        begin
            if (fault_tally != '1)
                fault_tally++;
            if (filled < lim)
            begin
                // Fill the next free frame: everything valid ages, out-of-limit frames too.
                f = filled;
                for (i = 0; i < FRAMES; i++)
                begin
                    if (held_valid[i])
                        age_rank[i]++;
                end
                held_page[f] = pg;
                held_valid[f] = 1'b1;
                age_rank[f] = 0;
                filled++;
            end
            else
            begin
                // Evict the oldest frame inside the limit; first index wins a tie.
                f = 0;
                for (i = 1; i < lim; i++)
                begin
                    if (age_rank[i] > age_rank[f])
                        f = i;
                end
                res.evicted = 1'b1;
                res.evicted_page = held_page[f];
                held_page[f] = pg;
                promote_frame(f);
            end
        end
        res.hit = found;
        res.frame = f[FRAME_INDEX_W-1:0];
        res.hit_total = hit_tally;
        res.fault_total = fault_tally;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    // Driver: predict each accepted word, hold a stalled word, otherwise send in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            page <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(predict_reference(page));
            // A stalled word stays put; otherwise advance to the next slot.
            if (!(in_valid && in_stall))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    // Mostly short bursts with short gaps, now and then a long unbroken run.
                    if ($urandom_range(0, 7) == 0)
                    begin
                        burst_left = $urandom_range(30, 80);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 10);
                        gap_left = $urandom_range(0, 5);
                    end
                end
                if (burst_left > 0 && page_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    page <= page_queue.pop_front();
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Monitor: check each accepted result word against the oldest expectation,
    // then choose next cycle's stall from the current back-pressure style.
    always @(posedge clk or negedge rst_n)
    begin
        page_outcome_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no page reference outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(hit));
                    compare_field("frame_index", 32'(want.frame), 32'(frame_index));
                    compare_field("evicted", 32'(want.evicted), 32'(evicted));
                    compare_field("evicted_page", 32'(want.evicted_page),
                                  32'(evicted_page));
                    compare_field("hit_total", want.hit_total, hit_total);
                    compare_field("fault_total", want.fault_total, fault_total);
                    words_checked++;
                    if (want.hit)
                        seen_hits++;
                    else
                        seen_faults++;
                    if (want.evicted)
                        seen_evictions++;
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
                stall_period = $urandom_range(2, 7);
            end
            else
            begin
                mode_left--;
            end
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: out_stall <= ((stall_tick % stall_period) == 0);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    // Wait until no word is queued, in flight on the input, or owed by the block.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (page_queue.size() != 0 || in_valid || pending_results.size() != 0);
    endtask

    // Write the frame limit once the block has drained and settled.
    task automatic write_limit(input logic [CFG_W-1:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
        cfg_write <= 1'b1;
        frame_limit <= value;
        limit_reg = value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        limit_writes++;
    endtask

    // Queue random references: mostly from a small working set so hits and
    // evictions both occur, the rest fully random so every page bit toggles.
    task automatic queue_random(input int count);
        logic [PAGE_BITS-1:0] working_set[$];
        int n;
        int k;
        n = $urandom_range(1, 24);
        for (k = 0; k < n; k++)
            working_set.push_back(PAGE_BITS'($urandom));
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) != 0)
                page_queue.push_back(working_set[$urandom_range(0, n - 1)]);
            else
                page_queue.push_back(PAGE_BITS'($urandom));
        end
    endtask

    // Limits used for the random phases: extremes, clamped values and a few mid-range.
    logic [CFG_W-1:0] phase_limits[] = '{5'd1, 5'd2, 5'd3, 5'd17, 5'd8, 5'd0,
                                         5'd31, 5'd5, 5'd16, 5'd12, 5'd4, 5'd16};

    initial
    begin
        int p;
        int per_phase;
        for (p = 0; p < FRAMES; p++)
        begin
            held_valid[p] = 1'b0;
            age_rank[p] = 0;
            held_page[p] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset limit of 16: all-zero and all-one pages, fills and hits.
        page_queue = '{16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'hA5A5};
        // Lower the limit to 2: page in frame 2 is now invisible, so it faults
        // and ends up held twice; then evict again and hit the new copy.
        write_limit(5'd2);
        page_queue = '{16'h1234, 16'h5A5A, 16'h1234};
        // Raise the limit: the duplicated page hits its lowest frame, new pages fill upward.
        write_limit(5'd16);
        page_queue = '{16'h1234, 16'h8000, 16'h0001};
        // A limit of zero acts as a single frame.
        write_limit(5'd0);
        page_queue = '{16'h7777, 16'h7777, 16'h0F0F};
        // A limit above the frame count acts as the full set.
        write_limit(5'd31);
        page_queue = '{16'h0F0F, 16'hC3C3};

        per_phase = (ITEMS_TOTAL - 17) / phase_limits.size();
        foreach (phase_limits[ph])
        begin
            write_limit(phase_limits[ph]);
            queue_random(per_phase);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            mismatches++;
        end
        $display("Checked %0d result words: %0d hits, %0d faults, %0d evictions.",
                 words_checked, seen_hits, seen_faults, seen_evictions);
        $display("Frame limit rewritten %0d times, including 0, 1, 16, 17 and 31.",
                 limit_writes);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d pages queued and %0d results outstanding.",
                 page_queue.size(), pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
